// File: hw/rtl/pow_solution_checker_defines.svh
// Assertion macros for the proof-of-work checker.
// Used by the top level only; no dependencies.
`ifndef POW_SOLUTION_CHECKER_DEFINES_SVH
`define POW_SOLUTION_CHECKER_DEFINES_SVH
`define PSC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define PSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// File: hw/rtl/psc_pkg.sv
// Types, constants and round functions for the proof-of-work checker.
// No dependencies.
package psc_pkg;
    localparam int unsigned ROUNDS = 64;
    localparam int unsigned TOTAL_CELLS = 2 * ROUNDS;

    typedef logic [31:0] t_word;
    typedef t_word t_state [8];

    typedef struct packed {
        logic         valid;
        logic         bad;
        logic [255:0] target;
        logic [255:0] hin;
        logic [255:0] abcd;
        logic [511:0] sched;
    } t_lane;

    localparam logic [255:0] INIT_H = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    localparam logic [31:0] ROUND_K [ROUNDS] = '{
        32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
        32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
        32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
        32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
        32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
        32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
        32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
        32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
        32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
        32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
        32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};

    function automatic t_word rotr(input t_word x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [255:0] add8(input logic [255:0] a, input logic [255:0] b);
        logic [255:0] r;
        for (int i = 0; i < 8; i++) r[32*i +: 32] = a[32*i +: 32] + b[32*i +: 32];
        return r;
    endfunction
endpackage

// File: hw/rtl/psc_if.sv
// Valid/ready channel interface for the proof-of-work checker.
// Depends on nothing; payload type is a parameter.
interface psc_if #(parameter type t_payload = logic) ();
    logic     valid;
    logic     ready;
    t_payload data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/psc_round_cell.sv
// One SHA-256 compression round with its message schedule step; a FINAL cell also adds the chaining value.
// Depends on psc_pkg.
module psc_round_cell #(
    parameter int unsigned ROUND = 0,
    parameter bit          FINAL = 1'b0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  psc_pkg::t_lane i_lane,
    output psc_pkg::t_lane o_lane
);
    psc_pkg::t_lane r_lane;
    psc_pkg::t_lane n_lane;
    psc_pkg::t_word a, b, c, d, e, f, g, h, t1, t2, w0, w1, w9, w14, s0, s1, wn;
    logic [255:0] st;

    always_comb begin
        {a, b, c, d, e, f, g, h} = i_lane.abcd;
        w0  = i_lane.sched[511 -: 32];
        w1  = i_lane.sched[479 -: 32];
        w9  = i_lane.sched[223 -: 32];
        w14 = i_lane.sched[63 -: 32];
        s0 = psc_pkg::rotr(w1, 7) ^ psc_pkg::rotr(w1, 18) ^ (w1 >> 3);
        s1 = psc_pkg::rotr(w14, 17) ^ psc_pkg::rotr(w14, 19) ^ (w14 >> 10);
        wn = w0 + s0 + w9 + s1;
        t1 = h + (psc_pkg::rotr(e, 6) ^ psc_pkg::rotr(e, 11) ^ psc_pkg::rotr(e, 25))
             + ((e & f) ^ (~e & g)) + psc_pkg::ROUND_K[ROUND] + w0;
        t2 = (psc_pkg::rotr(a, 2) ^ psc_pkg::rotr(a, 13) ^ psc_pkg::rotr(a, 22))
             + ((a & b) ^ (a & c) ^ (b & c));
        st = {t1 + t2, a, b, c, d + t1, e, f, g};
        n_lane = i_lane;
        n_lane.abcd = st;
        n_lane.sched = {i_lane.sched[479:0], wn};
        if (FINAL) begin
            n_lane.hin  = psc_pkg::add8(i_lane.hin, st);
            n_lane.abcd = psc_pkg::add8(i_lane.hin, st);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane.valid <= 1'b0;
        end else if (i_en) begin
            r_lane.valid <= n_lane.valid;
        end
        if (i_en) begin
            r_lane.bad    <= n_lane.bad;
            r_lane.target <= n_lane.target;
            r_lane.hin    <= n_lane.hin;
            r_lane.abcd   <= n_lane.abcd;
            r_lane.sched  <= n_lane.sched;
        end
    end

    assign o_lane = r_lane;
endmodule

// File: hw/rtl/psc_target.sv
// Expands the compact difficulty to a 256-bit target.
// Depends on nothing.
module psc_target (
    input  logic [7:0]   i_exponent,
    input  logic [23:0]  i_mantissa,
    output logic [255:0] o_target,
    output logic         o_bad
);
    logic [8:0]   sh;
    logic [255:0] base;
    assign o_bad = i_exponent < 8'd3;
    assign sh    = {1'b0, i_exponent} - 9'd3;
    assign base  = {232'd0, i_mantissa};
    assign o_target = (o_bad || sh > 9'd34) ? 256'd0 : (base << {sh[5:0], 3'b000});
endmodule

// File: hw/rtl/pow_solution_checker.sv
// Top level of the proof-of-work checker: 128-cell SHA-256d round chain.
// Depends on psc_pkg, psc_if, psc_round_cell, psc_target, defines header.
//
// channel  dir  payload
// i_in     in   exponent, mantissa, seed_word0..3, candidate_nonce
// o_out    out  accepted, bad_difficulty
//
// One item per cycle while the output is not stalled; 128 round cells plus one output register.
// The chain advances as a whole when the output register is empty or taken.
// Reset clears all valid bits; a stall at the output holds every cell.
`include "pow_solution_checker_defines.svh"
module pow_solution_checker (
    input logic i_clk,
    input logic i_rst_n,
    psc_if.sink   i_in,
    psc_if.source o_out
);
    localparam int unsigned N = psc_pkg::TOTAL_CELLS;
    psc_pkg::t_lane lanes [N+1];
    psc_pkg::t_lane mid;
    logic [255:0] tgt;
    logic bad, en;
    logic r_valid, r_acc, r_bad;

    assign en = !r_valid || o_out.ready;
    assign i_in.ready = en;

    psc_target u_tgt (.i_exponent(i_in.data.difficulty_exponent),
        .i_mantissa(i_in.data.difficulty_mantissa), .o_target(tgt), .o_bad(bad));

    always_comb begin
        lanes[0].valid  = i_in.valid;
        lanes[0].bad    = bad;
        lanes[0].target = tgt;
        lanes[0].hin    = psc_pkg::INIT_H;
        lanes[0].abcd   = psc_pkg::INIT_H;
        lanes[0].sched  = {i_in.data.seed_word0, i_in.data.seed_word1, i_in.data.seed_word2,
                           i_in.data.seed_word3, i_in.data.candidate_nonce,
                           32'h80000000, 128'd0, 32'd320};
        mid = lanes[psc_pkg::ROUNDS];
        mid.sched = {lanes[psc_pkg::ROUNDS].abcd, 32'h80000000, 192'd0, 32'd256};
        mid.hin   = psc_pkg::INIT_H;
        mid.abcd  = psc_pkg::INIT_H;
    end

    for (genvar i = 0; i < N; i++) begin : g_cell
        psc_round_cell #(.ROUND(i % psc_pkg::ROUNDS),
            .FINAL((i % psc_pkg::ROUNDS) == psc_pkg::ROUNDS - 1)) u_cell (
            .i_clk, .i_rst_n, .i_en(en),
            .i_lane((i == psc_pkg::ROUNDS) ? mid : lanes[i]), .o_lane(lanes[i+1]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= lanes[N].valid;
        end
        if (en) begin
            r_bad <= lanes[N].bad;
            r_acc <= !lanes[N].bad && (lanes[N].target > lanes[N].abcd);
        end
    end

    assign o_out.valid = r_valid;
    assign o_out.data.accepted = r_acc;
    assign o_out.data.bad_difficulty = r_bad;

    `PSC_ASSERT_IMPL(a_flags_excl, i_clk, i_rst_n, r_valid, !(r_acc && r_bad))
    `PSC_ASSERT_NEXT(a_hold_stall, i_clk, i_rst_n, r_valid && !o_out.ready,
        r_valid && $stable(r_acc) && $stable(r_bad))
    `PSC_ASSERT_IMPL(a_ready_en, i_clk, i_rst_n, !r_valid, i_in.ready)
endmodule
